// ===== design/dlpd_pkg.sv =====
// ----------------------------------------------------------------------------
// dlpd_pkg
// Shared types and constants for the decimal length prefix deframer.
// ----------------------------------------------------------------------------
package dlpd_pkg;

    localparam int unsigned HEADER_DIGITS_DEF = 10;
    localparam int unsigned LEN_W             = 34;
    localparam int unsigned BYTE_W            = 8;
    localparam int unsigned QUEUE_DEPTH       = 4;
    localparam int unsigned QUEUE_AW          = $clog2(QUEUE_DEPTH);

    localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] ASCII_NINE = 8'h39;
    localparam logic [LEN_W-1:0]  LEN_MAX    = {LEN_W{1'b1}};

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic              message_start;
        logic              message_end;
        logic              empty_message;
        logic [LEN_W-1:0]  message_length;
    } t_word;

endpackage

// ===== design/dlpd_front.sv =====
// ----------------------------------------------------------------------------
// dlpd_front
// Header parser and payload tracker. Classifies each byte and builds the
// result word for payload bytes and empty frames.
// ----------------------------------------------------------------------------
module dlpd_front #(
    parameter int unsigned HEADER_DIGITS = dlpd_pkg::HEADER_DIGITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [dlpd_pkg::BYTE_W-1:0]   i_data_byte,
    output logic                          o_push,
    output dlpd_pkg::t_word               o_word
);

    localparam int unsigned POS_W = $clog2(HEADER_DIGITS + 1);
    localparam int unsigned MUL_W = dlpd_pkg::LEN_W + 4;

    logic [POS_W-1:0]              r_pos, n_pos;
    logic [dlpd_pkg::LEN_W-1:0]    r_acc, n_acc;
    logic                          r_stopped, n_stopped;
    logic [dlpd_pkg::LEN_W-1:0]    r_remain, n_remain;
    logic                          r_in_payload, n_in_payload;
    logic [dlpd_pkg::LEN_W-1:0]    r_frame_len, n_frame_len;

    logic                          is_digit;
    logic [3:0]                    digit;
    logic [MUL_W-1:0]              acc_wide;
    logic [MUL_W-1:0]              acc_next;
    logic [dlpd_pkg::LEN_W-1:0]    acc_sat;
    logic [POS_W-1:0]              pos_inc;
    logic [dlpd_pkg::LEN_W-1:0]    remain_dec;

    assign is_digit = (i_data_byte >= dlpd_pkg::ASCII_ZERO) &&
                      (i_data_byte <= dlpd_pkg::ASCII_NINE);
    assign digit    = 4'(i_data_byte - dlpd_pkg::ASCII_ZERO);
    assign acc_wide = {4'b0, r_acc};
    assign acc_next = (acc_wide << 3) + (acc_wide << 1) + MUL_W'(digit);
    assign acc_sat  = (acc_next > {4'b0, dlpd_pkg::LEN_MAX}) ? dlpd_pkg::LEN_MAX
                                                             : acc_next[dlpd_pkg::LEN_W-1:0];
    assign pos_inc  = r_pos + POS_W'(1);
    assign remain_dec = (r_remain != '0) ? (r_remain - dlpd_pkg::LEN_W'(1)) : r_remain;

    always_comb begin
        n_pos        = r_pos;
        n_acc        = r_acc;
        n_stopped    = r_stopped;
        n_remain     = r_remain;
        n_in_payload = r_in_payload;
        n_frame_len  = r_frame_len;
        o_push       = 1'b0;
        o_word       = '0;

        if (i_accept) begin
            if (r_in_payload) begin
                o_push                = 1'b1;
                o_word.payload_byte   = i_data_byte;
                o_word.message_start  = (r_remain == r_frame_len);
                o_word.message_end    = (r_remain <= dlpd_pkg::LEN_W'(1));
                o_word.message_length = r_frame_len;
                n_remain              = remain_dec;
                if (remain_dec == '0) begin
                    n_in_payload = 1'b0;
                    n_pos        = '0;
                    n_acc        = '0;
                    n_stopped    = 1'b0;
                end
            end else begin
                if (!r_stopped && is_digit) begin
                    n_acc = acc_sat;
                end else begin
                    n_stopped = 1'b1;
                end
                n_pos = pos_inc;
                if (pos_inc >= POS_W'(HEADER_DIGITS)) begin
                    n_frame_len = n_acc;
                    n_pos       = '0;
                    n_acc       = '0;
                    n_stopped   = 1'b0;
                    if (n_frame_len == '0) begin
                        o_push               = 1'b1;
                        o_word.empty_message = 1'b1;
                    end else begin
                        n_remain     = n_frame_len;
                        n_in_payload = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_acc        <= '0;
            r_stopped    <= 1'b0;
            r_remain     <= '0;
            r_in_payload <= 1'b0;
            r_frame_len  <= '0;
        end else begin
            r_pos        <= n_pos;
            r_acc        <= n_acc;
            r_stopped    <= n_stopped;
            r_remain     <= n_remain;
            r_in_payload <= n_in_payload;
            r_frame_len  <= n_frame_len;
        end
    end

endmodule

// ===== design/dlpd_queue.sv =====
// ----------------------------------------------------------------------------
// dlpd_queue
// Small word queue between the parser and the output stage.
// ----------------------------------------------------------------------------
module dlpd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  dlpd_pkg::t_word i_word,
    input  logic            i_pop,
    output dlpd_pkg::t_word o_head,
    output logic            o_full,
    output logic            o_empty
);

    dlpd_pkg::t_word                r_mem [dlpd_pkg::QUEUE_DEPTH];
    logic [dlpd_pkg::QUEUE_AW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [dlpd_pkg::QUEUE_AW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [dlpd_pkg::QUEUE_AW:0]    r_count, n_count;

    assign o_full  = (r_count == (dlpd_pkg::QUEUE_AW+1)'(dlpd_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ===== design/dlpd_back.sv =====
// ----------------------------------------------------------------------------
// dlpd_back
// Output register stage: pulls words from the queue and holds them until
// the downstream side takes them.
// ----------------------------------------------------------------------------
module dlpd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  dlpd_pkg::t_word i_head,
    input  logic            i_empty,
    input  logic            i_stall,
    output logic            o_pop,
    output logic            o_valid,
    output dlpd_pkg::t_word o_word
);

    logic            r_valid, n_valid;
    dlpd_pkg::t_word r_word;

    assign o_pop   = !i_empty && (!r_valid || !i_stall);
    assign n_valid = o_pop || (r_valid && i_stall);
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_word <= i_head;
        end
    end

endmodule

// ===== design/decimal_length_prefix_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// decimal_length_prefix_deframer_unit
// Splits a byte stream into frames with a zero-padded ASCII decimal length
// header and passes payload bytes on with start, end and length marks.
//
//   channel  direction  handshake              fields
//   input    in         i_valid / o_stall      i_data_byte
//   output   out        o_valid / i_stall      o_payload_byte, o_message_start,
//                                              o_message_end, o_empty_message,
//                                              o_message_length
//
// One byte is taken every cycle while the four-word queue has room.
// Header bytes give no word, except the last byte of a zero-length header.
// o_stall rises only when the queue is full, i.e. downstream has stalled.
// Synchronous active-low reset returns the parser to the first header digit.
// ----------------------------------------------------------------------------
module decimal_length_prefix_deframer_unit #(
    parameter int unsigned HEADER_DIGITS = dlpd_pkg::HEADER_DIGITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [dlpd_pkg::BYTE_W-1:0]  i_data_byte,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [dlpd_pkg::BYTE_W-1:0]  o_payload_byte,
    output logic                         o_message_start,
    output logic                         o_message_end,
    output logic                         o_empty_message,
    output logic [dlpd_pkg::LEN_W-1:0]   o_message_length
);

    logic            accept;
    logic            push;
    logic            pop;
    logic            q_full;
    logic            q_empty;
    dlpd_pkg::t_word front_word;
    dlpd_pkg::t_word head_word;
    dlpd_pkg::t_word out_word;

    assign o_stall = q_full;
    assign accept  = i_valid && !q_full;

    dlpd_front #(
        .HEADER_DIGITS (HEADER_DIGITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .o_push      (push),
        .o_word      (front_word)
    );

    dlpd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (front_word),
        .i_pop   (pop),
        .o_head  (head_word),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    dlpd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head_word),
        .i_empty (q_empty),
        .i_stall (i_stall),
        .o_pop   (pop),
        .o_valid (o_valid),
        .o_word  (out_word)
    );

    assign o_payload_byte   = out_word.payload_byte;
    assign o_message_start  = out_word.message_start;
    assign o_message_end    = out_word.message_end;
    assign o_empty_message  = out_word.empty_message;
    assign o_message_length = out_word.message_length;

endmodule

// ===== verif/decimal_length_prefix_deframer_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// decimal_length_prefix_deframer_unit_tb
// Drives a framed byte stream into the deframer and predicts every output
// word from its own copy of the header parser and payload countdown.
// Directed frames cover empty, one-byte and short frames, signs, spaces and
// other non-digits in the header, and the largest ten-digit length. Random
// frames follow, mostly well formed with some broken headers. The sender
// idles in bursts. The receiver stalls on its own pattern and twice holds
// off long enough to back the block up.
// ----------------------------------------------------------------------------
module decimal_length_prefix_deframer_unit_tb;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 8;
    localparam int STREAM_BYTES   = 1000;
    localparam int HOLDOFF_CYCLES = 200;
    localparam int DRAIN_CYCLES   = 20;
    localparam int CYCLE_LIMIT    = 500000;

    class deframe_scoreboard;
        int unsigned                hdr_pos;
        logic [dlpd_pkg::LEN_W-1:0] len_acc;
        bit                         digits_stopped;
        logic [dlpd_pkg::LEN_W-1:0] bytes_left;
        bit                         in_payload;
        logic [dlpd_pkg::LEN_W-1:0] frame_len;
        dlpd_pkg::t_word            due_words[$];
        int                         mismatches;

        function new();
            clear_header();
            bytes_left = '0;
            in_payload = 1'b0;
            frame_len  = '0;
            mismatches = 0;
        endfunction

        function void clear_header();
            hdr_pos        = 0;
            len_acc        = '0;
            digits_stopped = 1'b0;
        endfunction

        function void note_byte(logic [dlpd_pkg::BYTE_W-1:0] b);
            dlpd_pkg::t_word w;
            logic [63:0]     next;
            if (in_payload) begin
                w.payload_byte   = b;
                w.message_start  = (bytes_left == frame_len);
                w.message_end    = (bytes_left <= 1);
                w.empty_message  = 1'b0;
                w.message_length = frame_len;
                due_words.push_back(w);
                if (bytes_left != 0) bytes_left--;
                if (bytes_left == 0) begin
                    in_payload = 1'b0;
                    clear_header();
                end
                return;
            end
            if (!digits_stopped && b >= dlpd_pkg::ASCII_ZERO &&
                b <= dlpd_pkg::ASCII_NINE) begin
                next    = 64'(len_acc) * 64'd10 + 64'(b - dlpd_pkg::ASCII_ZERO);
                len_acc = (next > 64'(dlpd_pkg::LEN_MAX)) ? dlpd_pkg::LEN_MAX
                                                          : next[dlpd_pkg::LEN_W-1:0];
            end else begin
                digits_stopped = 1'b1;
            end
            hdr_pos++;
            if (hdr_pos >= dlpd_pkg::HEADER_DIGITS_DEF) begin
                frame_len = len_acc;
                clear_header();
                if (frame_len == 0) begin
                    w = '0;
                    w.empty_message = 1'b1;
                    due_words.push_back(w);
                end else begin
                    bytes_left = frame_len;
                    in_payload = 1'b1;
                end
            end
        endfunction

        task report_mismatch(string msg);
            $display("mismatch: %s", msg);
            mismatches++;
        endtask

        task check_word(dlpd_pkg::t_word got);
            dlpd_pkg::t_word exp;
            if (due_words.size() == 0) begin
                report_mismatch($sformatf("word %h with none outstanding", got));
                return;
            end
            exp = due_words.pop_front();
            if (got.payload_byte !== exp.payload_byte)
                report_mismatch($sformatf("payload_byte got %h want %h",
                                          got.payload_byte, exp.payload_byte));
            if (got.message_start !== exp.message_start)
                report_mismatch($sformatf("message_start got %b want %b",
                                          got.message_start, exp.message_start));
            if (got.message_end !== exp.message_end)
                report_mismatch($sformatf("message_end got %b want %b",
                                          got.message_end, exp.message_end));
            if (got.empty_message !== exp.empty_message)
                report_mismatch($sformatf("empty_message got %b want %b",
                                          got.empty_message, exp.empty_message));
            if (got.message_length !== exp.message_length)
                report_mismatch($sformatf("message_length got %0d want %0d",
                                          got.message_length, exp.message_length));
        endtask
    endclass

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_valid = 1'b0;
    logic                        o_stall;
    logic [dlpd_pkg::BYTE_W-1:0] i_data_byte = '0;
    logic                        o_valid;
    logic                        i_stall = 1'b0;
    logic [dlpd_pkg::BYTE_W-1:0] o_payload_byte;
    logic                        o_message_start;
    logic                        o_message_end;
    logic                        o_empty_message;
    logic [dlpd_pkg::LEN_W-1:0]  o_message_length;

    deframe_scoreboard sb = new();
    int  cycle_count = 0;
    int  bytes_sent  = 0;
    int  burst_left  = 0;
    bit  holdoff_req = 1'b0;

    decimal_length_prefix_deframer_unit DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_data_byte      (i_data_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_payload_byte   (o_payload_byte),
        .o_message_start  (o_message_start),
        .o_message_end    (o_message_end),
        .o_empty_message  (o_empty_message),
        .o_message_length (o_message_length)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_word('{payload_byte:   o_payload_byte,
                            message_start:  o_message_start,
                            message_end:    o_message_end,
                            empty_message:  o_empty_message,
                            message_length: o_message_length});
        end
    end

    // receiver stall pattern; long hold-off on request
    initial begin : rx_stall_pattern
        int mode;
        int span;
        @(posedge i_rst_n);
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(16, 160);
            repeat (span) begin
                @(posedge i_clk);
                if (holdoff_req) begin
                    holdoff_req = 1'b0;
                    i_stall <= 1'b1;
                    repeat (HOLDOFF_CYCLES) @(posedge i_clk);
                end
                case (mode)
                    0: begin
                        i_stall <= 1'b0;
                    end
                    1: begin
                        i_stall <= ($urandom_range(0, 4) == 0);
                    end
                    2: begin
                        i_stall <= ($urandom_range(0, 1) == 1);
                    end
                    default: begin
                        i_stall <= ($urandom_range(0, 4) != 0);
                    end
                endcase
            end
        end
    end

    task automatic send_byte(input logic [dlpd_pkg::BYTE_W-1:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid     <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (o_stall);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic send_payload_rest();
        while (sb.in_payload) send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic send_random_frame();
        int                          len;
        int                          cut;
        string                       hdr;
        logic [dlpd_pkg::BYTE_W-1:0] junk;
        if ($urandom_range(0, 7) == 0) len = $urandom_range(13, 64);
        else len = $urandom_range(0, 12);
        hdr = $sformatf("%010d", len);
        if ($urandom_range(0, 9) < 2) begin
            // broken header: non-digit at a random spot, anything after it
            cut = $urandom_range(0, dlpd_pkg::HEADER_DIGITS_DEF - 1);
            for (int i = 0; i < cut; i++) send_byte(hdr[i]);
            do junk = 8'($urandom_range(0, 255));
            while (junk >= dlpd_pkg::ASCII_ZERO && junk <= dlpd_pkg::ASCII_NINE);
            send_byte(junk);
            for (int i = cut + 1; i < dlpd_pkg::HEADER_DIGITS_DEF; i++)
                send_byte(8'($urandom_range(0, 255)));
        end else begin
            send_text(hdr);
        end
        send_payload_rest();
    endtask

    initial begin : stimulus
        bit second_holdoff;
        second_holdoff = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_text("0000000000");
        send_text("0000000001");
        send_byte(8'hFF);
        send_text("0000000003");
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h5A);
        send_text("-000000005");
        send_text("+000000002");
        send_text(" 000000002");
        send_text("00012x4567");
        send_payload_rest();
        send_text("0000000/02");
        send_text("000000002:");
        send_payload_rest();
        send_text("0000001");
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte("9");
        send_payload_rest();
        send_text("0000000010");
        send_payload_rest();

        holdoff_req = 1'b1;
        while (bytes_sent < STREAM_BYTES) begin
            send_random_frame();
            if (!second_holdoff && bytes_sent > STREAM_BYTES / 2) begin
                second_holdoff = 1'b1;
                holdoff_req = 1'b1;
            end
        end

        // largest ten-digit length; stream ends inside its payload
        send_text("9999999999");
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h33);
        i_valid <= 1'b0;

        while (sb.due_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.due_words.size() != 0)
            sb.report_mismatch("outstanding words never arrived");
        if (sb.mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
